### rtl/assert_macros.svh
// Assertion helpers for the RTL; all checks sample on clk and
// stay quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define UVS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define UVS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/uvs_pkg.sv
// ---------------------------------------------------------------------------
// uvs_pkg
// Types, constants and arithmetic helpers for the UV-sphere cell tessellator.
// ---------------------------------------------------------------------------
package uvs_pkg;

  localparam int MAX_DIVISIONS = 1024;

  // Register indexes
  localparam logic REG_RING_COUNT  = 1'b0;
  localparam logic REG_SLICE_COUNT = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_COUNT = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  // Quadrant codes of a phase
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Divider: integer step plus 32 fraction bits, four bits per stage
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = 32 / DIV_BITS;

  // CORDIC: 30 steps, two per stage
  localparam int CORDIC_STEPS     = 30;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_STAGES    = CORDIC_STEPS / CORDIC_PER_STAGE;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  localparam logic signed [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5,
    32'sd3,         32'sd1
  };

  typedef struct packed {
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic [30:0]        sphere_radius;
    logic [31:0]        color_word;
    logic [1:0]         status;
  } uvs_side_t;

  // floor((a*b + 2^29) / 2^30)
  function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                  input logic signed [33:0] b);
    logic signed [67:0] p;
    p = 68'(a * b) + (68'sd1 <<< 29);
    return p[63:30];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v[34:31] == 4'b0000 || v[34:31] == 4'b1111) begin
      r = v[31:0];
    end else if (v[34]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

### rtl/uv_sphere_cell_tessellator.sv
// Throughput: two triangles on the output channel per cell, and one cell per cycle
// for cells that give an error result, while out_tready stays high.
// Rate is set by the output channel, one triangle per cycle while out_tready is
// high; all stages share one advance enable driven by the output register.
// Reset: synchronous active-low rst_n clears valid bits; counts reset to 16.
// ---------------------------------------------------------------------------
// uv_sphere_cell_tessellator
// Splits one latitude-longitude sphere cell into two Q16.16 triangles (one zeroed result on error).
// ---------------------------------------------------------------------------
module uv_sphere_cell_tessellator import uvs_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  // configuration
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [10:0]  cfg_wdata,
  // cell requests
  input  logic         in_tvalid,
  output logic         in_tready,
  // center_x[31:0], center_y[63:32], center_z[95:64], sphere_radius[126:96],
  // ring_index[136:127], slice_index[146:137], color_word[178:147], zero pad
  input  logic [183:0] in_tdata,
  // triangles
  output logic         out_tvalid,
  input  logic         out_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, tri_color, 32 bits each
  output logic [319:0] out_tdata,
  // status
  output logic [1:0]   out_tuser,
  output logic         out_tlast   // last_of_cell
);

  localparam int SB_DEPTH = DIV_STAGES + CORDIC_STAGES + 3;
  localparam int SB_M1    = DIV_STAGES + CORDIC_STAGES;

  logic [10:0] ring_count_r, slice_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ring_count_r  <= 11'd16;
      slice_count_r <= 11'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RING_COUNT:  ring_count_r  <= cfg_wdata;
        REG_SLICE_COUNT: slice_count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---- request fields
  logic [9:0] in_ring, in_slice;
  logic       cfg_bad, idx_bad;
  uvs_side_t  side_in;

  assign in_ring  = in_tdata[136:127];
  assign in_slice = in_tdata[146:137];

  assign cfg_bad = (ring_count_r < 11'd2) || (slice_count_r < 11'd3) ||
                   (ring_count_r > 11'(MAX_DIVISIONS)) ||
                   (slice_count_r > 11'(MAX_DIVISIONS));
  assign idx_bad = ({1'b0, in_ring} >= ring_count_r) ||
                   ({1'b0, in_slice} >= slice_count_r);

  always_comb begin
    side_in.center_x      = $signed(in_tdata[31:0]);
    side_in.center_y      = $signed(in_tdata[63:32]);
    side_in.center_z      = $signed(in_tdata[95:64]);
    side_in.sphere_radius = in_tdata[126:96];
    side_in.color_word    = in_tdata[178:147];
    if (cfg_bad) begin
      side_in.status = ST_BAD_COUNT;
    end else if (idx_bad) begin
      side_in.status = ST_BAD_INDEX;
    end else begin
      side_in.status = ST_OK;
    end
  end

  // ---- advance control
  logic       adv;
  logic       ov_r, phase_r;
  logic [1:0] ost_r;
  logic       out_last;

  assign out_last  = (ost_r != ST_OK) || phase_r;
  assign adv       = !ov_r || (out_tready && out_last);
  assign in_tready = adv;

  // ---- side band shift line with valid bits
  uvs_side_t sb_r  [SB_DEPTH];
  logic      vld_r [SB_DEPTH];
  logic [9:0] ring_r, slice_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SB_DEPTH; i++) vld_r[i] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < SB_DEPTH; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= side_in;
      ring_r  <= in_ring;
      slice_r <= in_slice;
      for (int i = 1; i < SB_DEPTH; i++) sb_r[i] <= sb_r[i-1];
    end
  end

  // ---- phases: theta = i*2^31/rings, phi = j*2^32/slices mod 2^32
  logic [32:0] q_t1, q_t2, q_p1, q_p2;

  uvs_div u_div_t1 (.clk, .en(adv), .num({1'b0, ring_r}),
                    .den(ring_count_r), .quo(q_t1));
  uvs_div u_div_t2 (.clk, .en(adv), .num(11'({1'b0, ring_r}) + 11'd1),
                    .den(ring_count_r), .quo(q_t2));
  uvs_div u_div_p1 (.clk, .en(adv), .num({1'b0, slice_r}),
                    .den(slice_count_r), .quo(q_p1));
  uvs_div u_div_p2 (.clk, .en(adv), .num(11'({1'b0, slice_r}) + 11'd1),
                    .den(slice_count_r), .quo(q_p2));

  logic signed [33:0] st1, ct1, st2, ct2, sp1, cp1, sp2, cp2;

  uvs_cordic u_cor_t1 (.clk, .en(adv), .phase(q_t1[32:1]), .sin_o(st1), .cos_o(ct1));
  uvs_cordic u_cor_t2 (.clk, .en(adv), .phase(q_t2[32:1]), .sin_o(st2), .cos_o(ct2));
  uvs_cordic u_cor_p1 (.clk, .en(adv), .phase(q_p1[31:0]), .sin_o(sp1), .cos_o(cp1));
  uvs_cordic u_cor_p2 (.clk, .en(adv), .phase(q_p2[31:0]), .sin_o(sp2), .cos_o(cp2));

  // ---- first multiply: radius by sin/cos of theta
  logic signed [33:0] rad_s;
  logic signed [33:0] rs1_r, rs2_r, yt1_r, yt2_r;
  logic signed [33:0] sp1_r, cp1_r, sp2_r, cp2_r;

  assign rad_s = $signed({3'b000, sb_r[SB_M1].sphere_radius});

  always_ff @(posedge clk) begin
    if (adv) begin
      rs1_r <= mul_q30(rad_s, st1);
      rs2_r <= mul_q30(rad_s, st2);
      yt1_r <= mul_q30(rad_s, ct1);
      yt2_r <= mul_q30(rad_s, ct2);
      sp1_r <= sp1;
      cp1_r <= cp1;
      sp2_r <= sp2;
      cp2_r <= cp2;
    end
  end

  // ---- second multiply: corner terms; corner index {theta edge, phi edge}
  logic signed [33:0] xt_r [4];
  logic signed [33:0] zt_r [4];
  logic signed [33:0] ya_r, yb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      xt_r[0] <= mul_q30(rs1_r, cp1_r);
      zt_r[0] <= mul_q30(rs1_r, sp1_r);
      xt_r[1] <= mul_q30(rs1_r, cp2_r);
      zt_r[1] <= mul_q30(rs1_r, sp2_r);
      xt_r[2] <= mul_q30(rs2_r, cp1_r);
      zt_r[2] <= mul_q30(rs2_r, sp1_r);
      xt_r[3] <= mul_q30(rs2_r, cp2_r);
      zt_r[3] <= mul_q30(rs2_r, sp2_r);
      ya_r    <= yt1_r;
      yb_r    <= yt2_r;
    end
  end

  // ---- add the centre, saturate, hold the cell for output
  uvs_side_t          sbl;
  logic signed [31:0] vx_r [4];
  logic signed [31:0] vy_r [4];
  logic signed [31:0] vz_r [4];
  logic [31:0]        ocol_r;

  assign sbl = sb_r[SB_DEPTH-1];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        vx_r[c] <= sat32(35'(sbl.center_x) + 35'(xt_r[c]));
        vz_r[c] <= sat32(35'(sbl.center_z) + 35'(zt_r[c]));
        vy_r[c] <= sat32(35'(sbl.center_y) + 35'((c < 2) ? ya_r : yb_r));
      end
      ocol_r <= sbl.color_word;
      ost_r  <= sbl.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r    <= 1'b0;
      phase_r <= 1'b0;
    end else if (adv) begin
      ov_r    <= vld_r[SB_DEPTH-1];
      phase_r <= 1'b0;
    end else if (out_tvalid && out_tready) begin
      // first triangle taken, advance to the second
      phase_r <= 1'b1;
    end
  end

  always_comb begin
    if (ost_r != ST_OK) begin
      out_tdata = '0;
    end else if (!phase_r) begin
      out_tdata = {ocol_r, vz_r[3], vy_r[3], vx_r[3], vz_r[1], vy_r[1], vx_r[1],
                   vz_r[0], vy_r[0], vx_r[0]};
    end else begin
      out_tdata = {ocol_r, vz_r[2], vy_r[2], vx_r[2], vz_r[3], vy_r[3], vx_r[3],
                   vz_r[0], vy_r[0], vx_r[0]};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tuser  = ost_r;
  assign out_tlast  = out_last;

`include "assert_macros.svh"

  `UVS_ASSERT_NEXT(a_second_tri, out_tvalid && out_tready && !out_tlast, out_tvalid && out_tlast && out_tuser == ST_OK, "second triangle of a cell missing")
  `UVS_ASSERT_NOW(a_no_idle_stall, !out_tvalid, in_tready, "pipeline stalled with an empty output")
  `UVS_ASSERT_NOW(a_err_zero, out_tvalid && out_tuser != ST_OK, out_tdata == '0 && out_tlast, "error result carries data")

endmodule

### rtl/uvs_div.sv
// ---------------------------------------------------------------------------
// uvs_div
// Pipelined long division num * 2^32 / den: integer bit and 32 fraction bits.
// ---------------------------------------------------------------------------
module uvs_div import uvs_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [10:0] num,
  input  logic [10:0] den,
  output logic [32:0] quo      // {integer bit, fraction[31:0]}
);

  logic [10:0] rem_r [DIV_STAGES];
  logic [32:0] quo_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [10:0] rem_in;
    logic [32:0] quo_in;
    logic [10:0] rem_nxt;
    logic [32:0] quo_nxt;
    logic [11:0] dbl;

    if (s == 0) begin : g_first
      // integer part of num / den
      assign rem_in = (num >= den) ? 11'(num - den) : num;
      assign quo_in = {32'd0, (num >= den)};
    end else begin : g_rest
      assign rem_in = rem_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      dbl     = '0;
      for (int b = 0; b < DIV_BITS; b++) begin
        dbl = {rem_nxt, 1'b0};
        if (dbl >= {1'b0, den}) begin
          rem_nxt = 11'(dbl - {1'b0, den});
          quo_nxt = {quo_nxt[31:0], 1'b1};
        end else begin
          rem_nxt = dbl[10:0];
          quo_nxt = {quo_nxt[31:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_nxt;
        quo_r[s] <= quo_nxt;
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];

endmodule

### rtl/uvs_cordic.sv
// ---------------------------------------------------------------------------
// uvs_cordic
// Pipelined rotation CORDIC: 32-bit turn phase to sine and cosine in Q2.30.
// ---------------------------------------------------------------------------
module uvs_cordic import uvs_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [31:0]        phase,
  output logic signed [33:0] sin_o,
  output logic signed [33:0] cos_o
);

  logic signed [33:0] x_r    [CORDIC_STAGES];
  logic signed [33:0] y_r    [CORDIC_STAGES];
  logic signed [31:0] z_r    [CORDIC_STAGES];
  logic [1:0]         quad_r [CORDIC_STAGES];

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
    logic signed [33:0] x_in, y_in, xv, yv, dx, dy, x_nxt, y_nxt;
    logic signed [31:0] z_in, zv;
    logic [1:0]         q_in;

    if (s == 0) begin : g_first
      assign x_in = CORDIC_X0;
      assign y_in = '0;
      assign z_in = $signed({2'b00, phase[29:0]});
      assign q_in = phase[31:30];
    end else begin : g_rest
      assign x_in = x_r[s-1];
      assign y_in = y_r[s-1];
      assign z_in = z_r[s-1];
      assign q_in = quad_r[s-1];
    end

    always_comb begin
      xv = x_in;
      yv = y_in;
      zv = z_in;
      dx = '0;
      dy = '0;
      for (int b = 0; b < CORDIC_PER_STAGE; b++) begin
        dx = yv >>> (s * CORDIC_PER_STAGE + b);
        dy = xv >>> (s * CORDIC_PER_STAGE + b);
        if (!zv[31]) begin
          xv = xv - dx;
          yv = yv + dy;
          zv = zv - ATAN_TURNS[s * CORDIC_PER_STAGE + b];
        end else begin
          xv = xv + dx;
          yv = yv - dy;
          zv = zv + ATAN_TURNS[s * CORDIC_PER_STAGE + b];
        end
      end
    end

    if (s == CORDIC_STAGES - 1) begin : g_last
      // fold the quadrant in: x carries cosine, y carries sine
      always_comb begin
        unique case (q_in)
          QUAD_0:  begin x_nxt = xv;  y_nxt = yv;  end
          QUAD_1:  begin x_nxt = -yv; y_nxt = xv;  end
          QUAD_2:  begin x_nxt = -xv; y_nxt = -yv; end
          QUAD_3:  begin x_nxt = yv;  y_nxt = -xv; end
          default: begin x_nxt = xv;  y_nxt = yv;  end
        endcase
      end
    end else begin : g_mid
      assign x_nxt = xv;
      assign y_nxt = yv;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[s]    <= x_nxt;
        y_r[s]    <= y_nxt;
        z_r[s]    <= zv;
        quad_r[s] <= q_in;
      end
    end
  end

  assign cos_o = x_r[CORDIC_STAGES-1];
  assign sin_o = y_r[CORDIC_STAGES-1];

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV-sphere cell tessellator testbench
// Drives sphere cells through several ring/slice settings, predicts both
// triangles (or the error result) per cell with a fixed-point CORDIC model
// and checks every triangle in order, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import uvs_pkg::*;

  typedef struct {
    logic [319:0] verts;
    logic [1:0]   status;
    logic         last;
  } tri_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic         cfg_index = REG_RING_COUNT;
  logic [10:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [183:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [319:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  logic [183:0] cell_q[$];
  tri_t         tri_q[$];
  int unsigned  ring_cnt = 16, slice_cnt = 16;
  int           errors = 0;
  int           cells_sent = 0, tris_seen = 0, err_tris = 0;
  bit           no_idle = 0;
  int           in_gap = 0, out_gap = 0, quiet = 0;

  uv_sphere_cell_tessellator dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // CORDIC sine/cosine of a phase in turns, Q2.30
  function automatic void sin_cos(input logic [31:0] ph, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = CORDIC_X0;
    y = 0;
    z = longint'(ph[29:0]);
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TURNS[k]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TURNS[k]);
      end
    end
    case (ph[31:30])
      QUAD_0: begin c = x;  s = y;  end
      QUAD_1: begin c = -y; s = x;  end
      QUAD_2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint rmul(input longint a, input longint b);
    return (a * b + (longint'(1) <<< 29)) >>> 30;
  endfunction

  function automatic logic [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [95:0] vertex(input logic [183:0] d, input logic [31:0] tp,
                                         input logic [31:0] pp);
    longint st, ct, sp, cp, rad, rs;
    logic [95:0] v;
    sin_cos(tp, st, ct);
    sin_cos(pp, sp, cp);
    rad = longint'(d[126:96]);
    rs = rmul(rad, st);
    v[31:0]  = clamp32(longint'(signed'(d[31:0]))  + rmul(rs, cp));
    v[63:32] = clamp32(longint'(signed'(d[63:32])) + rmul(rad, ct));
    v[95:64] = clamp32(longint'(signed'(d[95:64])) + rmul(rs, sp));
    return v;
  endfunction

  // Expected triangles of one cell under the current counts
  function automatic void tessellate(input logic [183:0] d);
    tri_t t;
    logic [63:0] ri, si;
    logic [31:0] t1, t2, p1, p2;
    logic [95:0] v00, v01, v10, v11;
    ri = 64'(d[136:127]);
    si = 64'(d[146:137]);
    t.verts = '0;
    t.last = 1'b1;
    if (ring_cnt < 2 || slice_cnt < 3 || ring_cnt > MAX_DIVISIONS
        || slice_cnt > MAX_DIVISIONS) begin
      t.status = ST_BAD_COUNT;
      tri_q.push_back(t);
      return;
    end
    if (ri >= ring_cnt || si >= slice_cnt) begin
      t.status = ST_BAD_INDEX;
      tri_q.push_back(t);
      return;
    end
    t1 = 32'((ri << 31) / ring_cnt);
    t2 = 32'(((ri + 1) << 31) / ring_cnt);
    p1 = 32'((si << 32) / slice_cnt);
    p2 = 32'(((si + 1) << 32) / slice_cnt);
    v00 = vertex(d, t1, p1);
    v01 = vertex(d, t1, p2);
    v10 = vertex(d, t2, p1);
    v11 = vertex(d, t2, p2);
    t.status = ST_OK;
    t.verts = {d[178:147], v11, v01, v00};
    t.last = 1'b0;
    tri_q.push_back(t);
    t.verts = {d[178:147], v10, v11, v00};
    t.last = 1'b1;
    tri_q.push_back(t);
  endfunction

  // Request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        tessellate(in_tdata);
        cells_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (cell_q.size() > 0) begin
          in_tdata <= cell_q.pop_front();
          in_tvalid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Triangle monitor
  always @(posedge clk) begin
    tri_t t;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        tris_seen++;
        if (out_tuser != ST_OK) err_tris++;
        if (tri_q.size() == 0) begin
          $display("%0t: unexpected triangle %h status %0d", $time, out_tdata, out_tuser);
          errors++;
        end else begin
          t = tri_q.pop_front();
          for (int n = 0; n < 10; n++)
            if (out_tdata[32*n +: 32] !== t.verts[32*n +: 32]) begin
              $display("%0t: word %0d expected %h actual %h", $time, n,
                       t.verts[32*n +: 32], out_tdata[32*n +: 32]);
              errors++;
            end
          if (out_tuser !== t.status) begin
            $display("%0t: status expected %0d actual %0d", $time, t.status, out_tuser);
            errors++;
          end
          if (out_tlast !== t.last) begin
            $display("%0t: last expected %0b actual %0b", $time, t.last, out_tlast);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // Watchdog: count stuck cycles while work is pending
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cell_q.size() == 0 && !in_tvalid && tri_q.size() == 0)) begin
      quiet <= 0;
    end else if (quiet >= 5000) begin
      $display("%0t: watchdog expired, %0d triangles outstanding", $time, tri_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [183:0] make_cell(input logic [31:0] cx, input logic [31:0] cy,
                                             input logic [31:0] cz, input logic [30:0] rad,
                                             input logic [9:0] ri, input logic [9:0] si,
                                             input logic [31:0] col);
    return {5'b0, col, si, ri, rad, cz, cy, cx};
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
      2: return {{8{$urandom_range(0, 1) == 1}}, 24'($urandom())};
      default: return ($urandom_range(0, 1) == 1) ? 32'h7fff_0000 : 32'h8001_0000;
    endcase
  endfunction

  function automatic logic [30:0] rand_radius();
    case ($urandom_range(0, 3))
      0: return 31'($urandom());
      1: return 31'($urandom_range(0, 32'h00ff_ffff));
      2: return 31'h7fff_ffff;
      default: return 31'($urandom_range(0, 65536 * 8));
    endcase
  endfunction

  function automatic logic [9:0] rand_index(input int unsigned cnt);
    if (cnt >= 1 && $urandom_range(0, 99) < 88)
      return 10'($urandom_range(0, (cnt > 1024 ? 1024 : cnt) - 1));
    return 10'($urandom());
  endfunction

  task automatic write_reg(input logic idx, input logic [10:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RING_COUNT) ring_cnt = 32'(val);
    else slice_cnt = 32'(val);
  endtask

  // Hold until every request is taken and every triangle is back, then drain
  task automatic settle();
    wait (cell_q.size() == 0 && !in_tvalid && tri_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    int unsigned rings[10] = '{2, 1024, 0, 1, 16, 1025, 2047, 7, 1024, 33};
    int unsigned slices[10] = '{3, 1024, 0, 16, 2, 16, 2047, 13, 3, 1024};
    int          per_phase;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed cells at the reset counts (16 x 16)
    cell_q.push_back(make_cell(0, 0, 0, 31'h0001_0000, 0, 0, 32'h0));
    cell_q.push_back(make_cell(0, 0, 0, 31'h0001_0000, 15, 15, 32'hffff_ffff));
    cell_q.push_back(make_cell(0, 0, 0, 31'h0001_0000, 16, 0, 32'h1234_5678));
    cell_q.push_back(make_cell(0, 0, 0, 31'h0001_0000, 0, 16, 32'h1234_5678));
    cell_q.push_back(make_cell(0, 0, 0, 31'h0001_0000, 1023, 1023, 32'h1));
    cell_q.push_back(make_cell(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff,
                               7, 3, 32'haaaa_5555));
    cell_q.push_back(make_cell(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff,
                               8, 11, 32'h5555_aaaa));
    cell_q.push_back(make_cell(32'h8000_0000, 32'h7fff_ffff, 0, 0, 4, 4, 32'h8000_0000));
    cell_q.push_back(make_cell(32'h0010_0000, 32'hfff0_0000, 32'h1, 31'h7fff_ffff,
                               15, 0, 32'h0));
    cell_q.push_back(make_cell(0, 0, 0, 31'h0040_0000, 0, 8, 32'hdead_beef));
    cell_q.push_back(make_cell(0, 0, 0, 31'h0040_0000, 8, 12, 32'hdead_beef));
    settle();

    for (int p = 0; p < 10; p++) begin
      write_reg(REG_RING_COUNT, 11'(rings[p]));
      write_reg(REG_SLICE_COUNT, 11'(slices[p]));
      no_idle = (p % 3 == 1);
      per_phase = (rings[p] < 2 || slices[p] < 3 || rings[p] > 1024 || slices[p] > 1024)
                  ? 60 : 300;
      if (rings[p] >= 2 && slices[p] >= 3 && rings[p] <= 1024 && slices[p] <= 1024) begin
        cell_q.push_back(make_cell(0, 0, 0, 31'h0001_0000, 10'(rings[p] - 1),
                                   10'(slices[p] - 1), 32'hffff_ffff));
        cell_q.push_back(make_cell(0, 0, 0, 31'h0001_0000, 0, 0, 32'h0));
      end
      for (int n = 0; n < per_phase; n++)
        cell_q.push_back(make_cell(rand_coord(), rand_coord(), rand_coord(), rand_radius(),
                                   rand_index(rings[p]), rand_index(slices[p]), $urandom()));
      settle();
    end

    $display("Covered %0d cells and %0d triangles (%0d error results) over 11 count settings.",
             cells_sent, tris_seen, err_tris);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
